### rtl/tlik_pkg.sv
// Shared constants, types and the arctangent table of the two-link arm solver.
package tlik_pkg;

  localparam int ANGLE_FRAC_BITS_DEF = 12;
  localparam int CORDIC_STAGES_DEF   = 16;

  localparam int VEC_W  = 50;
  localparam int CX_W   = 53;
  localparam int Z_W    = 33;
  localparam int ANG_W  = 31;
  localparam int ROOT_W = 31;
  localparam int RAD_W  = 62;

  localparam logic [33:0] PI_Q30      = 34'd3373259426;
  localparam logic [33:0] HALF_PI_Q30 = 34'd1686629713;
  localparam logic [33:0] TWO_PI_Q30  = 34'd6746518852;

  localparam logic [15:0] LINK_RESET = 16'd2240;

  typedef enum logic [0:0] {
    REG_UPPER = 1'b0,
    REG_LOWER = 1'b1
  } reg_idx_t;

  typedef struct packed {
    logic signed [16:0] x;
    logic signed [16:0] y;
    logic               numneg;
    logic               reach;
    logic [30:0]        d;
    logic [30:0]        m;
  } side_t;

  typedef struct packed {
    logic xneg;
    logic yneg;
    logic bneg;
    logic numneg;
    logic reach;
  } flg_t;

  function automatic logic [29:0] atan_q30(input logic [4:0] i);
    logic [29:0] r;
    case (i)
      5'd0:  r = 30'd843314856;
      5'd1:  r = 30'd497837829;
      5'd2:  r = 30'd263043836;
      5'd3:  r = 30'd133525158;
      5'd4:  r = 30'd67021686;
      5'd5:  r = 30'd33543515;
      5'd6:  r = 30'd16775850;
      5'd7:  r = 30'd8388437;
      5'd8:  r = 30'd4194282;
      5'd9:  r = 30'd2097149;
      5'd10: r = 30'd1048575;
      5'd11: r = 30'd524287;
      5'd12: r = 30'd262143;
      5'd13: r = 30'd131071;
      5'd14: r = 30'd65535;
      5'd15: r = 30'd32767;
      5'd16: r = 30'd16383;
      5'd17: r = 30'd8191;
      5'd18: r = 30'd4095;
      5'd19: r = 30'd2047;
      5'd20: r = 30'd1023;
      5'd21: r = 30'd511;
      5'd22: r = 30'd255;
      5'd23: r = 30'd127;
      5'd24: r = 30'd63;
      5'd25: r = 30'd31;
      5'd26: r = 30'd15;
      5'd27: r = 30'd7;
      5'd28: r = 30'd3;
      5'd29: r = 30'd1;
      default: r = 30'd0;
    endcase
    return r;
  endfunction

endpackage

### rtl/two_link_arm_inverse_kinematics.sv
// Top level of the two-link planar arm inverse kinematics pipeline.
//
//  Channel  Direction  Signals                          Content
//  s_*      in         s_tvalid s_tready s_tdata        target point
//  m_*      out        m_tvalid m_tready m_tdata m_tuser  joint angles, reach flag
//  APB      in/out     psel penable pwrite paddr ...    link lengths
//
// One item enters per cycle while the output is not stalled.
// The pipeline runs through the 31-stage square root and the CORDIC stages.
// Reset clears only the valid bits and sets both link lengths to 140 mm.
// A stalled output freezes the whole pipeline, so no item is lost or repeated.
module two_link_arm_inverse_kinematics #(
  parameter int ANGLE_FRAC_BITS = tlik_pkg::ANGLE_FRAC_BITS_DEF,
  parameter int CORDIC_STAGES   = tlik_pkg::CORDIC_STAGES_DEF
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [39:0] s_tdata,   // target_x[16:0], target_y[33:17], zero fill
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [31:0] m_tdata,   // shoulder_angle[15:0], elbow_angle[29:16], zero fill
  output logic [0:0]  m_tuser,   // reachable[0]
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [2:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);

  localparam int LAT = 41 + CORDIC_STAGES;
  localparam int SH  = 30 - ANGLE_FRAC_BITS;
  localparam int QW  = tlik_pkg::ROOT_W;
  localparam int VW  = tlik_pkg::VEC_W;

  logic [15:0] upper_link_length;
  logic [15:0] lower_link_length;

  assign pready = 1'b1;
  assign prdata = {16'd0, (paddr[2] == tlik_pkg::REG_LOWER) ? lower_link_length
                                                           : upper_link_length};

  always_ff @(posedge clk) begin
    if (rst) begin
      upper_link_length <= tlik_pkg::LINK_RESET;
      lower_link_length <= tlik_pkg::LINK_RESET;
    end else if (psel && penable && pwrite) begin
      case (tlik_pkg::reg_idx_t'(paddr[2]))
        tlik_pkg::REG_UPPER: upper_link_length <= pwdata[15:0];
        tlik_pkg::REG_LOWER: lower_link_length <= pwdata[15:0];
        default: ;
      endcase
    end
  end

  logic en;
  logic [LAT-1:0] vld;

  assign en       = !vld[LAT-1] || m_tready;
  assign s_tready = en;
  assign m_tvalid = vld[LAT-1];

  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= '0;
    end else if (en) begin
      vld <= {vld[LAT-2:0], s_tvalid};
    end
  end

  logic signed [16:0] in_x, in_y;
  assign in_x = s_tdata[16:0];
  assign in_y = s_tdata[33:17];

  // Squares and link products.
  logic signed [16:0] a_x, a_y;
  logic [32:0] a_x2, a_y2;
  logic [31:0] a_l1sq, a_l2sq, a_l12;
  logic signed [33:0] xx, yy;

  assign xx = in_x * in_x;
  assign yy = in_y * in_y;

  always_ff @(posedge clk) begin
    if (en) begin
      a_x    <= in_x;
      a_y    <= in_y;
      a_x2   <= xx[32:0];
      a_y2   <= yy[32:0];
      a_l1sq <= upper_link_length * upper_link_length;
      a_l2sq <= lower_link_length * lower_link_length;
      a_l12  <= upper_link_length * lower_link_length;
    end
  end

  // Cosine numerator, denominator and reach test.
  logic signed [35:0] num;
  logic [35:0] mag;
  logic [32:0] den;
  logic reach_c;

  assign num = $signed({3'd0, a_x2}) + $signed({3'd0, a_y2})
             - $signed({4'd0, a_l1sq}) - $signed({4'd0, a_l2sq});
  assign mag = (num < 0) ? 36'(-num) : 36'(num);
  assign den = {a_l12, 1'b0};
  assign reach_c = (den != '0) && (mag <= 36'(den));

  logic signed [16:0] b_x, b_y;
  logic [32:0] b_d, b_m;
  logic b_numneg, b_reach, b_dz;

  always_ff @(posedge clk) begin
    if (en) begin
      b_x      <= a_x;
      b_y      <= a_y;
      b_d      <= den;
      b_m      <= reach_c ? mag[32:0] : den;
      b_numneg <= (num < 0);
      b_reach  <= reach_c;
      b_dz     <= (den == '0);
    end
  end

  // Normalize the denominator into [2^30, 2^31).
  logic [5:0]  msb;
  logic [32:0] d_n, m_n;

  always_comb begin
    msb = '0;
    for (int j = 0; j < 33; j++) begin
      if (b_d[j]) begin
        msb = 6'(j);
      end
    end
    if (b_dz) begin
      d_n = 33'd1 << 30;
      m_n = 33'd1 << 30;
    end else if (msb >= 6'd31) begin
      d_n = b_d >> (msb - 6'd30);
      m_n = b_m >> (msb - 6'd30);
    end else begin
      d_n = b_d << (6'd30 - msb);
      m_n = b_m << (6'd30 - msb);
    end
  end

  tlik_pkg::side_t c_side, d_side, e_side;

  always_ff @(posedge clk) begin
    if (en) begin
      c_side.x      <= b_x;
      c_side.y      <= b_y;
      c_side.numneg <= b_numneg;
      c_side.reach  <= b_reach;
      c_side.d      <= d_n[30:0];
      c_side.m      <= m_n[30:0];
    end
  end

  logic [61:0] d_dd, d_mm, e_v;

  always_ff @(posedge clk) begin
    if (en) begin
      d_dd   <= c_side.d * c_side.d;
      d_mm   <= c_side.m * c_side.m;
      d_side <= c_side;
      e_v    <= d_dd - d_mm;
      e_side <= d_side;
    end
  end

  logic [QW-1:0] s_root;

  tlik_isqrt u_isqrt (
    .clk      (clk),
    .en       (en),
    .radicand (e_v),
    .root     (s_root)
  );

  tlik_pkg::side_t q_side [1:QW];

  for (genvar k = 1; k <= QW; k++) begin : g_qside
    always_ff @(posedge clk) begin
      if (en) begin
        q_side[k] <= (k == 1) ? e_side : q_side[(k == 1) ? 1 : k - 1];
      end
    end
  end

  // Correction vector products.
  logic [46:0] f_p1, f_p2, f_ls;
  logic [QW-1:0] f_s;
  tlik_pkg::side_t f_side;

  always_ff @(posedge clk) begin
    if (en) begin
      f_p1   <= upper_link_length * q_side[QW].d;
      f_p2   <= lower_link_length * q_side[QW].m;
      f_ls   <= lower_link_length * s_root;
      f_s    <= s_root;
      f_side <= q_side[QW];
    end
  end

  logic signed [48:0] bsum;
  assign bsum = f_side.numneg ? $signed({2'd0, f_p1}) - $signed({2'd0, f_p2})
                              : $signed({2'd0, f_p1}) + $signed({2'd0, f_p2});

  logic [VW-1:0] g_bab, g_ls, g_m, g_s, g_ax, g_ay;
  tlik_pkg::flg_t g_flg;

  always_ff @(posedge clk) begin
    if (en) begin
      g_bab        <= (bsum < 0) ? VW'(-bsum) : VW'(bsum);
      g_ls         <= VW'(f_ls);
      g_m          <= VW'(f_side.m);
      g_s          <= VW'(f_s);
      g_ax         <= (f_side.x < 0) ? VW'(-(18'(f_side.x))) : VW'(f_side.x);
      g_ay         <= (f_side.y < 0) ? VW'(-(18'(f_side.y))) : VW'(f_side.y);
      g_flg.xneg   <= (f_side.x < 0);
      g_flg.yneg   <= (f_side.y < 0);
      g_flg.bneg   <= (bsum < 0);
      g_flg.numneg <= f_side.numneg;
      g_flg.reach  <= f_side.reach;
    end
  end

  logic [tlik_pkg::ANG_W-1:0] z_el, z_br, z_ps;

  tlik_cordic #(.STAGES(CORDIC_STAGES)) u_elbow (
    .clk (clk), .en (en), .ax (g_m), .ay (g_s), .angle (z_el)
  );

  tlik_cordic #(.STAGES(CORDIC_STAGES)) u_bearing (
    .clk (clk), .en (en), .ax (g_ax), .ay (g_ay), .angle (z_br)
  );

  tlik_cordic #(.STAGES(CORDIC_STAGES)) u_psi (
    .clk (clk), .en (en), .ax (g_bab), .ay (g_ls), .angle (z_ps)
  );

  tlik_pkg::flg_t k_flg [0:CORDIC_STAGES];

  for (genvar k = 0; k <= CORDIC_STAGES; k++) begin : g_kflg
    always_ff @(posedge clk) begin
      if (en) begin
        k_flg[k] <= (k == 0) ? g_flg : k_flg[(k == 0) ? 0 : k - 1];
      end
    end
  end

  // Angle assembly.
  tlik_pkg::flg_t kf;
  logic signed [35:0] elb, brg0, brg1, brg, psi;

  assign kf   = k_flg[CORDIC_STAGES];
  assign elb  = kf.numneg ? $signed(36'(tlik_pkg::PI_Q30)) - $signed(36'(z_el))
                          : $signed(36'(z_el));
  assign brg0 = kf.xneg ? $signed(36'(tlik_pkg::PI_Q30)) - $signed(36'(z_br))
                        : $signed(36'(z_br));
  assign brg1 = kf.yneg ? $signed(36'(tlik_pkg::TWO_PI_Q30)) - brg0 : brg0;
  assign brg  = (brg1 >= $signed(36'(tlik_pkg::TWO_PI_Q30)))
              ? brg1 - $signed(36'(tlik_pkg::TWO_PI_Q30)) : brg1;
  assign psi  = kf.bneg ? -$signed(36'(z_ps)) : $signed(36'(z_ps));

  logic signed [35:0] h_sh, h_el;
  logic h_reach;

  always_ff @(posedge clk) begin
    if (en) begin
      h_sh    <= brg - psi;
      h_el    <= elb;
      h_reach <= kf.reach;
    end
  end

  logic signed [35:0] sh_r, el_r;
  logic [15:0] sh_sat;
  logic [13:0] el_sat;

  assign sh_r = (h_sh + $signed(36'(1) << (SH - 1))) >>> SH;
  assign el_r = (h_el + $signed(36'(1) << (SH - 1))) >>> SH;

  always_comb begin
    if (sh_r > 36'sd32767) begin
      sh_sat = 16'h7FFF;
    end else if (sh_r < -36'sd32768) begin
      sh_sat = 16'h8000;
    end else begin
      sh_sat = sh_r[15:0];
    end
    if (el_r > 36'sd16383) begin
      el_sat = 14'h3FFF;
    end else if (el_r < 0) begin
      el_sat = '0;
    end else begin
      el_sat = el_r[13:0];
    end
  end

  logic [15:0] out_sh;
  logic [13:0] out_el;
  logic        out_reach;

  always_ff @(posedge clk) begin
    if (en) begin
      out_sh    <= sh_sat;
      out_el    <= el_sat;
      out_reach <= h_reach;
    end
  end

  assign m_tdata = {2'd0, out_el, out_sh};
  assign m_tuser = out_reach;

endmodule

### rtl/tlik_isqrt.sv
// Pipelined floor square root, one result bit per stage.
module tlik_isqrt (
  input  logic                         clk,
  input  logic                         en,
  input  logic [tlik_pkg::RAD_W-1:0]   radicand,
  output logic [tlik_pkg::ROOT_W-1:0]  root
);

  localparam int RW = tlik_pkg::RAD_W;
  localparam int QW = tlik_pkg::ROOT_W;

  logic [RW-1:0] rem [1:QW];
  logic [QW-1:0] rt  [1:QW];

  for (genvar k = 0; k < QW; k++) begin : g_step
    localparam int B = QW - 1 - k;
    logic [RW-1:0] cur_rem;
    logic [QW-1:0] cur_rt;
    logic [RW-1:0] test;
    if (k == 0) begin : g_first
      assign cur_rem = radicand;
      assign cur_rt  = '0;
    end else begin : g_rest
      assign cur_rem = rem[k];
      assign cur_rt  = rt[k];
    end
    assign test = (RW'(cur_rt) << (B + 1)) | (RW'(1) << (2 * B));
    always_ff @(posedge clk) begin
      if (en) begin
        if (cur_rem >= test) begin
          rem[k+1] <= cur_rem - test;
          rt[k+1]  <= cur_rt | (QW'(1) << B);
        end else begin
          rem[k+1] <= cur_rem;
          rt[k+1]  <= cur_rt;
        end
      end
    end
  end

  assign root = rt[QW];

endmodule

### rtl/tlik_cordic.sv
// Pipelined vectoring CORDIC giving atan(ay/ax) in the first quadrant.
module tlik_cordic #(
  parameter int STAGES = tlik_pkg::CORDIC_STAGES_DEF
) (
  input  logic                        clk,
  input  logic                        en,
  input  logic [tlik_pkg::VEC_W-1:0]  ax,
  input  logic [tlik_pkg::VEC_W-1:0]  ay,
  output logic [tlik_pkg::ANG_W-1:0]  angle
);

  localparam int W  = tlik_pkg::CX_W;
  localparam int ZW = tlik_pkg::Z_W;
  localparam int VW = tlik_pkg::VEC_W;

  logic signed [W-1:0]  cx [0:STAGES];
  logic signed [W-1:0]  cy [0:STAGES];
  logic signed [ZW-1:0] z  [0:STAGES];
  logic                 ay0 [0:STAGES];
  logic                 ax0 [0:STAGES];

  logic [VW-1:0] orv;
  logic [4:0]    sh;

  always_comb begin
    orv = ax | ay;
    sh = '0;
    for (int j = 0; j < 30; j++) begin
      if (orv[j]) begin
        sh = 5'(30 - j);
      end
    end
    if (orv[VW-1:30] != '0) begin
      sh = '0;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      cx[0]  <= $signed(W'(ax) << sh);
      cy[0]  <= $signed(W'(ay) << sh);
      z[0]   <= '0;
      ay0[0] <= (ay == '0);
      ax0[0] <= (ax == '0);
    end
  end

  for (genvar i = 0; i < STAGES; i++) begin : g_stage
    localparam int TI = (i < 32) ? i : 31;
    logic signed [ZW-1:0] a;
    assign a = $signed(ZW'(tlik_pkg::atan_q30(5'(TI))));
    always_ff @(posedge clk) begin
      if (en) begin
        if (cy[i] >= 0) begin
          cx[i+1] <= cx[i] + (cy[i] >>> i);
          cy[i+1] <= cy[i] - (cx[i] >>> i);
          z[i+1]  <= z[i] + a;
        end else begin
          cx[i+1] <= cx[i] - (cy[i] >>> i);
          cy[i+1] <= cy[i] + (cx[i] >>> i);
          z[i+1]  <= z[i] - a;
        end
        ay0[i+1] <= ay0[i];
        ax0[i+1] <= ax0[i];
      end
    end
  end

  always_comb begin
    if (ay0[STAGES]) begin
      angle = '0;
    end else if (ax0[STAGES]) begin
      angle = tlik_pkg::HALF_PI_Q30[30:0];
    end else if (z[STAGES] < 0) begin
      angle = '0;
    end else if (z[STAGES][31:0] > tlik_pkg::HALF_PI_Q30[31:0]) begin
      angle = tlik_pkg::HALF_PI_Q30[30:0];
    end else begin
      angle = z[STAGES][30:0];
    end
  end

endmodule
